FILE: src/piecewise_linear_colormap_core_assert.svh
`ifndef PIECEWISE_LINEAR_COLORMAP_CORE_ASSERT_SVH
`define PIECEWISE_LINEAR_COLORMAP_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PLCM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("colormap check failed");

// next-cycle implication, disabled in reset
`define PLCM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("colormap check failed");

`endif

FILE: src/plcm_pkg.sv
package plcm_pkg;

    localparam int NUM_SEG = 7;
    localparam int VALUE_W = 19;

    typedef logic [7:0] chan_t;
    typedef logic [2:0] seg_idx_t;

    typedef struct packed {
        logic     hit;
        seg_idx_t seg;
        logic     half_span;
    } seg_info_t;

    // segment bounds in halves: 1, 2, 2.5, 3, 3.5, 4, 5, 6
    localparam logic [3:0] BOUND_HALVES [0:NUM_SEG] = '{
        4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd10, 4'd12
    };

    localparam chan_t PALETTE [0:NUM_SEG][0:2] = '{
        '{8'd71,  8'd71,  8'd219},
        '{8'd0,   8'd0,   8'd91},
        '{8'd0,   8'd255, 8'd255},
        '{8'd0,   8'd128, 8'd0},
        '{8'd255, 8'd255, 8'd0},
        '{8'd255, 8'd96,  8'd0},
        '{8'd107, 8'd0,   8'd0},
        '{8'd224, 8'd76,  8'd76}
    };

endpackage

FILE: src/piecewise_linear_colormap_core.sv
// Channel | Direction | Ports
// s_      | in        | s_valid, s_ready, s_scalar_value
// m_      | out       | m_valid, m_ready, m_red, m_green, m_blue, m_segment, m_in_range
//
// One request per cycle sustained while m_ready is high.
// Path: input register -> segment decode + 17x9 multiply -> result register.
// aresetn (sync, active low) clears both valid flags; data registers are not reset.
// A stalled result is held; the input register still takes one more request.
module piecewise_linear_colormap_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [plcm_pkg::VALUE_W-1:0]  s_scalar_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output plcm_pkg::chan_t               m_red,
    output plcm_pkg::chan_t               m_green,
    output plcm_pkg::chan_t               m_blue,
    output plcm_pkg::seg_idx_t            m_segment,
    output logic                          m_in_range
);
    import plcm_pkg::*;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [VALUE_W-1:0]   in_value_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    chan_t                red_reg;
    chan_t                green_reg;
    chan_t                blue_reg;
    seg_idx_t             segment_reg;
    logic                 in_range_reg;

    logic                 adv_out;
    logic                 adv_in;
    seg_info_t            info;
    logic [FRAC_BITS-1:0] prop;
    seg_idx_t             seg_nx;
    chan_t                red_c;
    chan_t                green_c;
    chan_t                blue_c;

    assign adv_out = !out_valid_reg || m_ready;
    assign adv_in  = s_valid && s_ready;
    assign s_ready = !in_valid_reg || adv_out;

    assign in_valid_next  = adv_in ? 1'b1 : (adv_out ? 1'b0 : in_valid_reg);
    assign out_valid_next = adv_out ? in_valid_reg : out_valid_reg;

    plcm_seg #(.FRAC_BITS(FRAC_BITS)) u_seg (
        .value (in_value_reg),
        .info  (info),
        .prop  (prop)
    );

    assign seg_nx = seg_idx_t'(info.seg + 3'd1);

    plcm_blend #(.FRAC_BITS(FRAC_BITS)) u_red (
        .c0   (PALETTE[info.seg][0]),
        .c1   (PALETTE[seg_nx][0]),
        .prop (prop),
        .chan (red_c)
    );

    plcm_blend #(.FRAC_BITS(FRAC_BITS)) u_green (
        .c0   (PALETTE[info.seg][1]),
        .c1   (PALETTE[seg_nx][1]),
        .prop (prop),
        .chan (green_c)
    );

    plcm_blend #(.FRAC_BITS(FRAC_BITS)) u_blue (
        .c0   (PALETTE[info.seg][2]),
        .c1   (PALETTE[seg_nx][2]),
        .prop (prop),
        .chan (blue_c)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_in) begin
            in_value_reg <= s_scalar_value;
        end
        if (adv_out && in_valid_reg) begin
            red_reg      <= info.hit ? red_c   : 8'd0;
            green_reg    <= info.hit ? green_c : 8'd0;
            blue_reg     <= info.hit ? blue_c  : 8'd0;
            segment_reg  <= info.hit ? info.seg : '0;
            in_range_reg <= info.hit;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_red      = red_reg;
    assign m_green    = green_reg;
    assign m_blue     = blue_reg;
    assign m_segment  = segment_reg;
    assign m_in_range = in_range_reg;

`include "piecewise_linear_colormap_core_assert.svh"

    `PLCM_ASSERT_NOW(a_black_out_of_range, aclk, aresetn, (m_valid && !m_in_range), (m_red == 8'd0 && m_green == 8'd0 && m_blue == 8'd0 && m_segment == 3'd0))
    `PLCM_ASSERT_NOW(a_seg_bound, aclk, aresetn, (m_valid && m_in_range), (m_segment <= 3'd6))
    `PLCM_ASSERT_NEXT(a_in_fill, aclk, aresetn, (s_valid && s_ready), (in_valid_reg))
    `PLCM_ASSERT_NEXT(a_in_hold, aclk, aresetn, (in_valid_reg && !adv_out), (in_valid_reg && out_valid_reg))

endmodule

FILE: src/plcm_seg.sv
module plcm_seg #(
    parameter int FRAC_BITS = 16
) (
    input  logic [plcm_pkg::VALUE_W-1:0] value,
    output plcm_pkg::seg_info_t          info,
    output logic [FRAC_BITS-1:0]         prop
);
    import plcm_pkg::*;

    localparam int CW = (FRAC_BITS + 4 > VALUE_W) ? FRAC_BITS + 4 : VALUE_W;

    logic [CW-1:0] v_ext;
    logic [CW-1:0] lo_sel;
    logic [CW-1:0] d;

    assign v_ext = CW'(value);

    always_comb begin
        logic [CW-1:0] lo;
        logic [CW-1:0] hi;
        info   = '0;
        lo_sel = '0;
        for (int r = 0; r < NUM_SEG; r++) begin
            lo = CW'(BOUND_HALVES[r]) << (FRAC_BITS - 1);
            hi = CW'(BOUND_HALVES[r + 1]) << (FRAC_BITS - 1);
            if (!info.hit && v_ext >= lo && v_ext < hi) begin
                info.hit       = 1'b1;
                info.seg       = seg_idx_t'(r);
                info.half_span = ((BOUND_HALVES[r + 1] - BOUND_HALVES[r]) == 4'd1);
                lo_sel         = lo;
            end
        end
    end

    assign d    = v_ext - lo_sel;
    assign prop = info.half_span ? {d[FRAC_BITS-2:0], 1'b0} : d[FRAC_BITS-1:0];

endmodule

FILE: src/plcm_blend.sv
module plcm_blend #(
    parameter int FRAC_BITS = 16
) (
    input  plcm_pkg::chan_t      c0,
    input  plcm_pkg::chan_t      c1,
    input  logic [FRAC_BITS-1:0] prop,
    output plcm_pkg::chan_t      chan
);
    import plcm_pkg::*;

    localparam int NW = FRAC_BITS + 11;

    logic signed [FRAC_BITS:0]   prop_s;
    logic signed [8:0]           diff;
    logic signed [FRAC_BITS+9:0] prod;
    logic signed [NW-1:0]        base;
    logic signed [NW-1:0]        num;
    logic [10:0]                 ceil_v;

    assign prop_s = $signed({1'b0, prop});
    assign diff   = $signed({1'b0, c1}) - $signed({1'b0, c0});
    assign prod   = prop_s * diff;
    assign base   = $signed({3'b000, c0, {FRAC_BITS{1'b0}}});
    assign num    = base + $signed({prod[FRAC_BITS+9], prod});
    assign ceil_v = 11'(num[NW-2:FRAC_BITS]) + 11'(|num[FRAC_BITS-1:0]);

    always_comb begin
        if (num[NW-1]) begin
            chan = '0;
        end else if (ceil_v > 11'd255) begin
            chan = 8'd255;
        end else begin
            chan = ceil_v[7:0];
        end
    end

endmodule
